// ===== rtl/core/nst_pkg.sv =====
`timescale 1ns / 1ps

package nst_pkg;

    // default sizing
    localparam int NUM_SEMS_DEF     = 32;
    localparam int WAIT_SLOTS_DEF   = 16;
    localparam int TASK_ID_BITS_DEF = 6;

    // commands
    localparam logic [1:0] CMD_OPEN   = 2'd0;
    localparam logic [1:0] CMD_WAIT   = 2'd1;
    localparam logic [1:0] CMD_SIGNAL = 2'd2;
    localparam logic [1:0] CMD_CLOSE  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_AGAIN   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [7:0]         REF_MAX   = 8'd255;
    localparam logic signed [15:0] COUNT_MAX = 16'sd32767;

    // one request beat
    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] name_key;
        logic [14:0] initial_count;
        logic [4:0]  handle_in;
        logic [5:0]  task_id;
    } nst_req_t;

    // one response beat
    typedef struct packed {
        logic [1:0] status;
        logic [4:0] handle_out;
        logic       blocked;
        logic       wake_valid;
        logic [5:0] woken_task;
    } nst_rsp_t;

    // one table entry
    typedef struct packed {
        logic [63:0]        name;
        logic [7:0]         refs;
        logic signed [15:0] count;
    } nst_entry_t;

endpackage

// ===== rtl/core/nst_engine.sv =====
`timescale 1ns / 1ps

module nst_engine #(
    parameter int NUM_SEMS     = nst_pkg::NUM_SEMS_DEF,
    parameter int WAIT_SLOTS   = nst_pkg::WAIT_SLOTS_DEF,
    parameter int TASK_ID_BITS = nst_pkg::TASK_ID_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  nst_pkg::nst_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output nst_pkg::nst_rsp_t rsp
);

    localparam int IW  = $clog2(NUM_SEMS);
    localparam int CW  = $clog2(NUM_SEMS + 1);
    localparam int SW  = $clog2(WAIT_SLOTS > 1 ? WAIT_SLOTS : 2);
    localparam int SAW = $clog2(NUM_SEMS * WAIT_SLOTS);
    localparam int TB  = TASK_ID_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_CLR  = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_SIG  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam logic signed [15:0] NEG_W = 16'sd0 - 16'(WAIT_SLOTS);

    logic [2:0] state_reg, state_next;

    // latched request
    nst_pkg::nst_req_t req_reg;
    logic [IW-1:0]     h_reg;

    // scan state
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic          cmp_v_reg, cmp_v_next;
    logic [IW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          free_found_reg, free_found_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [IW-1:0] claim_reg, claim_next;
    logic [SW-1:0] k_reg, k_next;
    logic [SAW-1:0] sa_reg, sa_next;

    logic [NUM_SEMS-1:0] in_use_reg, in_use_next;
    nst_pkg::nst_rsp_t   rsp_reg, rsp_next;

    // entry memory
    nst_pkg::nst_entry_t ent_mem [NUM_SEMS];
    nst_pkg::nst_entry_t ent_rd;
    nst_pkg::nst_entry_t ent_wd;
    logic [IW-1:0]       ent_ra, ent_wa;
    logic                ent_we;

    // wait slot memory
    logic [TB:0]    slot_mem [NUM_SEMS * WAIT_SLOTS];
    logic [TB:0]    slot_rd, slot_wd;
    logic [SAW-1:0] slot_ra, slot_wa;
    logic           slot_we;

    // helpers
    logic [IW+4:0]  hx;
    logic [TB+5:0]  task_x;
    logic [TB+5:0]  woken_x;
    logic [IW+4:0]  hout_x;
    logic [IW+4:0]  claim_x;
    logic           match, cur_free, last;
    logic [IW-1:0]  pick;
    logic signed [15:0] nv_w, nv_s, neg_old, neg_nv;

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_wa] <= ent_wd;
        end
        ent_rd <= ent_mem[ent_ra];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wa] <= slot_wd;
        end
        slot_rd <= slot_mem[slot_ra];
    end

    assign hx        = {{IW{1'b0}}, req.handle_in};
    assign task_x    = {{TB{1'b0}}, req_reg.task_id};
    assign woken_x   = {6'd0, slot_rd[TB-1:0]};
    assign hout_x    = {5'd0, cmp_idx_reg};
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_DONE);
    assign rsp       = rsp_reg;

    // shared compare for the name scan
    assign match    = cmp_v_reg && in_use_reg[cmp_idx_reg] && (ent_rd.name == req_reg.name_key);
    assign cur_free = cmp_v_reg && !in_use_reg[cmp_idx_reg];
    assign last     = cmp_v_reg && (cmp_idx_reg == IW'(NUM_SEMS - 1));
    assign pick     = free_found_reg ? free_idx_reg : cmp_idx_reg;
    assign claim_x  = {5'd0, claim_reg};

    assign nv_w    = ent_rd.count - 16'sd1;
    assign nv_s    = ent_rd.count + 16'sd1;
    assign neg_old = 16'sd0 - ent_rd.count;
    assign neg_nv  = 16'sd0 - nv_s;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_v_next      = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        claim_next      = claim_reg;
        k_next          = k_reg;
        sa_next         = sa_reg;
        in_use_next     = in_use_reg;
        rsp_next        = rsp_reg;
        ent_ra          = hx[IW-1:0];
        ent_we          = 1'b0;
        ent_wa          = h_reg;
        ent_wd          = ent_rd;
        slot_ra         = sa_reg;
        slot_we         = 1'b0;
        slot_wa         = sa_reg;
        slot_wd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    rsp_next        = '0;
                    scan_idx_next   = '0;
                    free_found_next = 1'b0;
                    if (req.command == nst_pkg::CMD_OPEN)
                    begin
                        state_next = S_SCAN;
                    end
                    else if ((32'(req.handle_in) >= 32'(NUM_SEMS)) ||
                             !in_use_reg[hx[IW-1:0]])
                    begin
                        rsp_next.status = nst_pkg::ST_INVALID;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_SCAN:
            begin
                // issue next read
                ent_ra = scan_idx_reg[IW-1:0];
                if (32'(scan_idx_reg) < 32'(NUM_SEMS))
                begin
                    cmp_v_next    = 1'b1;
                    cmp_idx_next  = scan_idx_reg[IW-1:0];
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                if (cur_free && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
                // compare the returned entry
                if (match)
                begin
                    cmp_v_next          = 1'b0;
                    rsp_next.handle_out = hout_x[4:0];
                    if (ent_rd.refs >= nst_pkg::REF_MAX)
                    begin
                        rsp_next.status = nst_pkg::ST_AGAIN;
                    end
                    else
                    begin
                        ent_we      = 1'b1;
                        ent_wa      = cmp_idx_reg;
                        ent_wd.refs = ent_rd.refs + 8'd1;
                    end
                    state_next = S_DONE;
                end
                else if (last)
                begin
                    cmp_v_next = 1'b0;
                    if (free_found_reg || cur_free)
                    begin
                        ent_we                = 1'b1;
                        ent_wa                = pick;
                        ent_wd.name           = req_reg.name_key;
                        ent_wd.refs           = 8'd1;
                        ent_wd.count          = {1'b0, req_reg.initial_count};
                        in_use_next[pick]     = 1'b1;
                        claim_next            = pick;
                        k_next                = '0;
                        state_next            = S_CLR;
                    end
                    else
                    begin
                        rsp_next.status = nst_pkg::ST_FULL;
                        state_next      = S_DONE;
                    end
                end
            end
            S_CLR:
            begin
                // wipe the wait slots of the claimed entry
                rsp_next.handle_out = claim_x[4:0];
                slot_we = 1'b1;
                slot_wa = SAW'(claim_reg) * SAW'(WAIT_SLOTS) + SAW'(k_reg);
                k_next  = k_reg + SW'(1);
                if (32'(k_reg) == WAIT_SLOTS - 1)
                begin
                    state_next = S_DONE;
                end
            end
            S_EXEC:
            begin
                unique case (req_reg.command)
                    nst_pkg::CMD_WAIT:
                    begin
                        if (nv_w < NEG_W)
                        begin
                            rsp_next.status = nst_pkg::ST_AGAIN;
                        end
                        else
                        begin
                            ent_we       = 1'b1;
                            ent_wd.count = nv_w;
                            if (nv_w < 16'sd0)
                            begin
                                slot_we = 1'b1;
                                slot_wa = SAW'(h_reg) * SAW'(WAIT_SLOTS) +
                                          SAW'(neg_old[SW-1:0]);
                                slot_wd = {1'b1, task_x[TB-1:0]};
                                rsp_next.blocked = 1'b1;
                            end
                        end
                        state_next = S_DONE;
                    end
                    nst_pkg::CMD_SIGNAL:
                    begin
                        state_next = S_DONE;
                        if (ent_rd.count < nst_pkg::COUNT_MAX)
                        begin
                            ent_we       = 1'b1;
                            ent_wd.count = nv_s;
                            if (nv_s <= 16'sd0)
                            begin
                                slot_ra = SAW'(h_reg) * SAW'(WAIT_SLOTS) +
                                          SAW'(neg_nv[SW-1:0]);
                                sa_next    = slot_ra;
                                state_next = S_SIG;
                            end
                        end
                    end
                    nst_pkg::CMD_CLOSE:
                    begin
                        ent_we      = 1'b1;
                        ent_wd.refs = ent_rd.refs - 8'd1;
                        if (ent_rd.refs == 8'd1)
                        begin
                            in_use_next[h_reg] = 1'b0;
                        end
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SIG:
            begin
                // release the newest waiter
                rsp_next.wake_valid = slot_rd[TB];
                rsp_next.woken_task = slot_rd[TB] ? woken_x[5:0] : 6'd0;
                slot_we    = 1'b1;
                slot_wa    = sa_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            in_use_reg     <= '0;
            cmp_v_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            in_use_reg     <= in_use_next;
            cmp_v_reg      <= cmp_v_next;
            free_found_reg <= free_found_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
        begin
            req_reg <= req;
            h_reg   <= hx[IW-1:0];
        end
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        free_idx_reg <= free_idx_next;
        claim_reg    <= claim_next;
        k_reg        <= k_next;
        sa_reg       <= sa_next;
        rsp_reg      <= rsp_next;
    end

endmodule

// ===== rtl/core/named_semaphore_table.sv =====
`timescale 1ns / 1ps

// Named counting semaphore table.
// Request channel: req_valid / req_stall with command, name_key, initial_count,
// handle_in and task_id. A beat is taken when req_valid is high and req_stall low.
// Response channel: rsp_valid / rsp_stall with status, handle_out, blocked,
// wake_valid and woken_task; one response beat per request beat, in order.
// One request is worked on at a time; req_stall is high while it is in flight.
// Open scans the entry memory one entry per cycle through a single name compare
// and stops at the first match, else runs to the end of the table; when it
// claims a new entry it then wipes that entry's wait slots. Wait, close and
// signal act in an execute state on the registered entry read; a signal that
// reaches a slot then takes the registered slot read in a further state, and a
// bad handle or a free entry is answered straight from idle.
// The response sits in an output register, so the next request is
// taken while a finished response waits on rsp_stall; a second finished
// response waits inside the engine until the output register frees up.
// Reset clears the in-use bits, so every entry is free; no clearing pass runs.

module named_semaphore_table #(
    parameter int NUM_SEMS     = nst_pkg::NUM_SEMS_DEF,
    parameter int WAIT_SLOTS   = nst_pkg::WAIT_SLOTS_DEF,
    parameter int TASK_ID_BITS = nst_pkg::TASK_ID_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  command,
    input  logic [63:0] name_key,
    input  logic [14:0] initial_count,
    input  logic [4:0]  handle_in,
    input  logic [5:0]  task_id,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  status,
    output logic [4:0]  handle_out,
    output logic        blocked,
    output logic        wake_valid,
    output logic [5:0]  woken_task
);

    nst_pkg::nst_req_t req;
    nst_pkg::nst_rsp_t eng_rsp;
    nst_pkg::nst_rsp_t out_reg;
    logic              eng_ready, eng_valid, eng_take;
    logic              out_valid_reg;

    assign req.command       = command;
    assign req.name_key      = name_key;
    assign req.initial_count = initial_count;
    assign req.handle_in     = handle_in;
    assign req.task_id       = task_id;

    nst_engine #(
        .NUM_SEMS     (NUM_SEMS),
        .WAIT_SLOTS   (WAIT_SLOTS),
        .TASK_ID_BITS (TASK_ID_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (eng_ready),
        .req       (req),
        .rsp_valid (eng_valid),
        .rsp_ready (eng_take),
        .rsp       (eng_rsp)
    );

    assign req_stall = !eng_ready;
    assign eng_take  = !out_valid_reg || !rsp_stall;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (eng_take)
        begin
            out_valid_reg <= eng_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_take && eng_valid)
        begin
            out_reg <= eng_rsp;
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign status     = out_reg.status;
    assign handle_out = out_reg.handle_out;
    assign blocked    = out_reg.blocked;
    assign wake_valid = out_reg.wake_valid;
    assign woken_task = out_reg.woken_task;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import nst_pkg::*;

    localparam int N_SEMS = 32;
    localparam int N_SLOTS = 16;
    localparam int COUNT_TOP = 32767;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [1:0]  command;
    logic [63:0] name_key;
    logic [14:0] initial_count;
    logic [4:0]  handle_in;
    logic [5:0]  task_id;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [1:0]  status;
    logic [4:0]  handle_out;
    logic        blocked;
    logic        wake_valid;
    logic [5:0]  woken_task;

    named_semaphore_table uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .command(command), .name_key(name_key), .initial_count(initial_count),
        .handle_in(handle_in), .task_id(task_id),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .status(status), .handle_out(handle_out), .blocked(blocked),
        .wake_valid(wake_valid), .woken_task(woken_task)
    );

    // shadow copy of the semaphore table
    int          sem_refs [N_SEMS];
    int          sem_level [N_SEMS];
    logic [63:0] sem_key [N_SEMS];
    bit          parked_valid [N_SEMS*N_SLOTS];
    logic [5:0]  parked_task [N_SEMS*N_SLOTS];

    nst_rsp_t pending_rsp[$];
    nst_rsp_t last_rsp;
    bit       failed;
    bit       quiet;

    typedef struct {
        nst_req_t req;
        bit       typed;
        nst_rsp_t want;
    } stim_row_t;

    stim_row_t stim_rows[$];

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int idle_gap();
        if (quiet)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    // next response of the semaphore table for one request
    function automatic nst_rsp_t semaphore_response(nst_req_t r);
        nst_rsp_t o;
        bit       done;
        int       h;
        int       old;
        int       nv;
        int       idx;
        o = '0;
        done = 1'b0;
        h = r.handle_in;
        if (r.command == CMD_OPEN)
        begin
            for (int e = 0; e < N_SEMS; e++)
            begin
                if (!done && sem_refs[e] != 0 && sem_key[e] == r.name_key)
                begin
                    done = 1'b1;
                    o.handle_out = 5'(e);
                    if (sem_refs[e] >= int'(REF_MAX))
                        o.status = ST_AGAIN;
                    else
                        sem_refs[e]++;
                end
            end
            for (int e = 0; e < N_SEMS; e++)
            begin
                if (!done && sem_refs[e] == 0)
                begin
                    done = 1'b1;
                    o.handle_out = 5'(e);
                    sem_refs[e] = 1;
                    sem_key[e] = r.name_key;
                    sem_level[e] = r.initial_count;
                    for (int k = 0; k < N_SLOTS; k++)
                        parked_valid[e*N_SLOTS+k] = 1'b0;
                end
            end
            if (!done)
                o.status = ST_FULL;
        end
        else if (sem_refs[h] == 0)
            o.status = ST_INVALID;
        else if (r.command == CMD_WAIT)
        begin
            old = sem_level[h];
            nv = old - 1;
            if (nv < -N_SLOTS)
                o.status = ST_AGAIN;
            else
            begin
                sem_level[h] = nv;
                if (nv < 0)
                begin
                    idx = h*N_SLOTS - old;
                    parked_valid[idx] = 1'b1;
                    parked_task[idx] = r.task_id;
                    o.blocked = 1'b1;
                end
            end
        end
        else if (r.command == CMD_SIGNAL)
        begin
            old = sem_level[h];
            if (old < COUNT_TOP)
            begin
                nv = old + 1;
                sem_level[h] = nv;
                if (nv <= 0)
                begin
                    idx = h*N_SLOTS - nv;
                    if (parked_valid[idx])
                    begin
                        o.wake_valid = 1'b1;
                        o.woken_task = parked_task[idx];
                    end
                    parked_valid[idx] = 1'b0;
                end
            end
        end
        else
            sem_refs[h]--;
        return o;
    endfunction

    // drive one request beat and hold it until it is taken
    task automatic send(nst_req_t r, bit typed, nst_rsp_t want);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        command <= r.command;
        name_key <= r.name_key;
        initial_count <= r.initial_count;
        handle_in <= r.handle_in;
        task_id <= r.task_id;
        do
            @(posedge clk);
        while (req_stall);
        last_rsp = semaphore_response(r);
        pending_rsp.push_back(typed ? want : last_rsp);
    endtask

    function automatic nst_req_t mk_req(logic [1:0] c, logic [63:0] k, logic [14:0] ic,
                                        logic [4:0] h, logic [5:0] t);
        nst_req_t r;
        r.command = c;
        r.name_key = k;
        r.initial_count = ic;
        r.handle_in = h;
        r.task_id = t;
        return r;
    endfunction

    function automatic void add_row(nst_req_t r, bit typed, logic [1:0] st, logic [4:0] ho,
                                    logic bl, logic wv, logic [5:0] wt);
        stim_row_t row;
        row.req = r;
        row.typed = typed;
        row.want.status = st;
        row.want.handle_out = ho;
        row.want.blocked = bl;
        row.want.wake_valid = wv;
        row.want.woken_task = wt;
        stim_rows.push_back(row);
    endfunction

    function automatic nst_req_t random_req(logic [63:0] keys[6]);
        nst_req_t r;
        int       pick;
        pick = $urandom_range(0, 99);
        r.command = pick < 25 ? CMD_OPEN : pick < 55 ? CMD_WAIT : pick < 85 ? CMD_SIGNAL
                    : CMD_CLOSE;
        r.name_key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                     : keys[$urandom_range(0, 5)];
        r.initial_count = ($urandom_range(0, 3) == 0) ? 15'($urandom)
                          : 15'($urandom_range(0, 2));
        r.handle_in = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 5));
        r.task_id = 6'($urandom);
        return r;
    endfunction

    // request side
    initial
    begin
        logic [63:0] keys[6];
        nst_rsp_t    none;
        int          h;
        none = '0;
        failed = 1'b0;
        quiet = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        command = CMD_OPEN;
        name_key = '0;
        initial_count = '0;
        handle_in = '0;
        task_id = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed part: extremes, every command, free entries, wake order
        add_row(mk_req(CMD_OPEN, 64'h0, 15'd0, 5'd0, 6'd0), 1, ST_OK, 5'd0, 0, 0, 0);
        add_row(mk_req(CMD_OPEN, '1, 15'h7fff, 5'd0, 6'd0), 1, ST_OK, 5'd1, 0, 0, 0);
        add_row(mk_req(CMD_WAIT, '1, '1, 5'd0, 6'd63), 1, ST_OK, 5'd0, 1, 0, 0);
        add_row(mk_req(CMD_WAIT, '0, '0, 5'd0, 6'd21), 1, ST_OK, 5'd0, 1, 0, 0);
        add_row(mk_req(CMD_SIGNAL, '0, '0, 5'd0, 6'd0), 1, ST_OK, 5'd0, 0, 1, 6'd21);
        add_row(mk_req(CMD_SIGNAL, '0, '0, 5'd0, 6'd0), 1, ST_OK, 5'd0, 0, 1, 6'd63);
        add_row(mk_req(CMD_SIGNAL, '0, '0, 5'd0, 6'd0), 0, 0, 0, 0, 0, 0);
        add_row(mk_req(CMD_SIGNAL, '0, '0, 5'd1, 6'd0), 1, ST_OK, 5'd0, 0, 0, 0);
        add_row(mk_req(CMD_WAIT, '0, '0, 5'd1, 6'd5), 0, 0, 0, 0, 0, 0);
        add_row(mk_req(CMD_WAIT, '0, '0, 5'd31, 6'd5), 1, ST_INVALID, 5'd0, 0, 0, 0);
        add_row(mk_req(CMD_SIGNAL, '0, '0, 5'd31, 6'd0), 1, ST_INVALID, 5'd0, 0, 0, 0);
        add_row(mk_req(CMD_CLOSE, '0, '0, 5'd31, 6'd0), 1, ST_INVALID, 5'd0, 0, 0, 0);
        add_row(mk_req(CMD_OPEN, 64'h0, 15'd9, 5'd0, 6'd0), 1, ST_OK, 5'd0, 0, 0, 0);
        add_row(mk_req(CMD_CLOSE, '0, '0, 5'd0, 6'd0), 1, ST_OK, 5'd0, 0, 0, 0);
        add_row(mk_req(CMD_CLOSE, '0, '0, 5'd0, 6'd0), 1, ST_OK, 5'd0, 0, 0, 0);
        add_row(mk_req(CMD_CLOSE, '0, '0, 5'd0, 6'd0), 1, ST_INVALID, 5'd0, 0, 0, 0);
        add_row(mk_req(CMD_OPEN, 64'h55aa, 15'd2, 5'd0, 6'd0), 1, ST_OK, 5'd0, 0, 0, 0);
        add_row(mk_req(CMD_CLOSE, '0, '0, 5'd1, 6'd0), 0, 0, 0, 0, 0, 0);
        add_row(mk_req(CMD_CLOSE, '0, '0, 5'd0, 6'd0), 0, 0, 0, 0, 0, 0);
        foreach (stim_rows[i])
            send(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].want);

        // wait queue runs full on a fresh entry
        send(mk_req(CMD_OPEN, 64'hfeed_0001, 15'd0, 5'd0, 6'd0), 0, none);
        h = last_rsp.handle_out;
        for (int i = 0; i < N_SLOTS + 2; i++)
            send(mk_req(CMD_WAIT, '0, '0, 5'(h), 6'($urandom)), 0, none);
        for (int i = 0; i < N_SLOTS + 2; i++)
            send(mk_req(CMD_SIGNAL, '0, '0, 5'(h), 6'($urandom)), 0, none);
        send(mk_req(CMD_CLOSE, '0, '0, 5'(h), 6'd0), 0, none);

        // drive one name's reference count into saturation while the table has room
        for (int i = 0; i < 257; i++)
            send(mk_req(CMD_OPEN, 64'hfeed_0002, 15'($urandom), 5'd0, 6'd0), 0, none);

        // random traffic over a small pool of names
        foreach (keys[i])
            keys[i] = {$urandom, $urandom};
        for (int i = 0; i < 380; i++)
        begin
            if (i % 150 == 100)
                quiet = 1'b1;
            if (i % 150 == 140)
                quiet = 1'b0;
            send(random_req(keys), 0, none);
        end

        // fill the table until it reports full
        for (int i = 0; i < N_SEMS + 1; i++)
            send(mk_req(CMD_OPEN, {$urandom, $urandom}, 15'($urandom), 5'($urandom),
                        6'($urandom)), 0, none);

        for (int i = 0; i < 120; i++)
            send(random_req(keys), 0, none);

        req_valid <= 1'b0;
        while (pending_rsp.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (!failed)
            $display("named_semaphore_table verification clean");
        else
            $display("named_semaphore_table verification failed");
        $finish;
    end

    // response side back-pressure
    initial
    begin
        int n;
        rsp_stall = 1'b1;
        @(posedge clk iff rst_n);
        forever
        begin
            n = idle_gap();
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!rsp_valid);
        end
    end

    // compare each response beat with the oldest expectation
    always @(posedge clk)
    begin
        nst_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response beat with nothing expected");
                failed = 1'b1;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, status);
                    failed = 1'b1;
                end
                if (handle_out !== want.handle_out)
                begin
                    $error("handle_out expected %0d actual %0d", want.handle_out, handle_out);
                    failed = 1'b1;
                end
                if (blocked !== want.blocked)
                begin
                    $error("blocked expected %0d actual %0d", want.blocked, blocked);
                    failed = 1'b1;
                end
                if (wake_valid !== want.wake_valid)
                begin
                    $error("wake_valid expected %0d actual %0d", want.wake_valid, wake_valid);
                    failed = 1'b1;
                end
                if (woken_task !== want.woken_task)
                begin
                    $error("woken_task expected %0d actual %0d", want.woken_task, woken_task);
                    failed = 1'b1;
                end
            end
        end
    end

    // hard stop
    initial
    begin
        #20_000_000;
        $display("named_semaphore_table verification failed");
        $finish;
    end

endmodule
